// ===== hdl/i2cms_pkg.sv =====
// Shared types, codes and constants for the two-wire master transfer sequencer.
package i2cms_pkg;

   localparam int BUF_DEPTH_DEF = 16;
   // Wide enough to compare any buffer position against the largest depth.
   localparam int CMP_W = 9;
   localparam int PTR_W = 5;
   localparam logic [PTR_W-1:0] PTR_MAX = 5'd31;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;

   localparam logic [7:0] STATUS_MASK = 8'hF8;
   localparam logic [7:0] RW_BIT_MASK = 8'h01;
   localparam logic [7:0] ADDR_MASK   = 8'hFE;

   // Bus status codes
   localparam logic [7:0] ST_START         = 8'h08;
   localparam logic [7:0] ST_REP_START     = 8'h10;
   localparam logic [7:0] ST_MTX_ADR_ACK   = 8'h18;
   localparam logic [7:0] ST_MTX_DATA_ACK  = 8'h28;
   localparam logic [7:0] ST_ARB_LOST      = 8'h38;
   localparam logic [7:0] ST_MRX_ADR_ACK   = 8'h40;
   localparam logic [7:0] ST_MRX_DATA_ACK  = 8'h50;
   localparam logic [7:0] ST_MRX_DATA_NACK = 8'h58;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EVENT = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SEND    = 3'd1,
      ACT_RX_ACK  = 3'd2,
      ACT_RX_NACK = 3'd3,
      ACT_STOP    = 3'd4,
      ACT_RESTART = 3'd5,
      ACT_ABORT   = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      OUT_NONE = 2'd0,
      OUT_OK   = 2'd1,
      OUT_ERR  = 2'd2
   } outcome_type;

   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_EXEC = 1'b1
   } seq_state_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  index;
      logic [7:0]  data_byte;
      logic [4:0]  count;
      logic [7:0]  status;
      logic [7:0]  rx_byte;
   } req_item_type;

   typedef struct packed {
      logic [PTR_W-1:0] ptr;
      logic [PTR_W-1:0] size;
      logic             busy;
      outcome_type      outcome;
      logic [7:0]       error;
   } seq_regs_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  tx_byte;
      logic [7:0]  read_byte;
   } step_rsp_type;

endpackage

// ===== hdl/i2c_master_transfer_sequencer.sv =====
// Top level of the two-wire master transfer sequencer: stream ports, control and state.
//
// Each request transaction gives exactly one response transaction. In the accept
// cycle (SEQ_IDLE) the message buffer memory is read (at the request index, at the
// byte pointer, or at position 0 for a start event); then, in SEQ_EXEC, the
// operation is applied, the buffer is written back and the response is registered.
// The sequencer returns to SEQ_IDLE and only then takes a new request, so it
// cannot accept a request before the previous one has been applied.
// The registered response may wait on rsp_tready while the next request is
// accepted; only the update cycle holds when the response register is still full.
module i2c_master_transfer_sequencer #(
   parameter int BUF_DEPTH = i2cms_pkg::BUF_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // index[3:0], data_byte[11:4], count[16:12], status[24:17], rx_byte[32:25], zero pad
   input  logic [i2cms_pkg::REQ_DATA_W-1:0]  req_tdata,
   // op[1:0]
   input  logic [i2cms_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // action[2:0], tx_byte[10:3], read_byte[18:11], busy_res[19], outcome[21:20],
   // error_status[29:22], zero pad
   output logic [i2cms_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import i2cms_pkg::*;

   localparam int AW = $clog2(BUF_DEPTH);

   seq_state_type          state_ff, state_in;
   seq_regs_type           regs_ff, regs_in;
   req_item_type           item_ff, req_item;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   seq_regs_type           step_nxt;
   step_rsp_type           step_rsp;
   logic                   step_wr_en;
   logic [AW-1:0]          step_wr_addr;
   logic [7:0]             step_wr_data;
   logic [7:0]             buf_data;

   logic                   req_fire;
   logic                   exec_go;
   logic [7:0]             req_st_m;
   logic [AW-1:0]          rd_addr;

   assign req_item.op        = op_type'(req_tuser);
   assign req_item.index     = req_tdata[3:0];
   assign req_item.data_byte = req_tdata[11:4];
   assign req_item.count     = req_tdata[16:12];
   assign req_item.status    = req_tdata[24:17];
   assign req_item.rx_byte   = req_tdata[32:25];

   assign req_tready = (state_ff == SEQ_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Start events rewind the pointer, so their send byte comes from position 0.
   always_comb begin
      req_st_m = req_item.status & STATUS_MASK;
      if (req_item.op == OP_EVENT) begin
         if ((req_st_m == ST_START) || (req_st_m == ST_REP_START)) begin
            rd_addr = '0;
         end else begin
            rd_addr = AW'(CMP_W'(regs_ff.ptr));
         end
      end else begin
         rd_addr = AW'(CMP_W'(req_item.index));
      end
   end

   i2cms_buf_mem #(
      .DEPTH (BUF_DEPTH),
      .AW    (AW)
   ) u_buf_mem (
      .clock   (clock),
      .wr_en   (step_wr_en && exec_go),
      .wr_addr (step_wr_addr),
      .wr_data (step_wr_data),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (buf_data)
   );

   i2cms_step #(
      .BUF_DEPTH (BUF_DEPTH),
      .AW        (AW)
   ) u_step (
      .item     (item_ff),
      .buf_data (buf_data),
      .cur      (regs_ff),
      .nxt      (step_nxt),
      .rsp      (step_rsp),
      .wr_en    (step_wr_en),
      .wr_addr  (step_wr_addr),
      .wr_data  (step_wr_data)
   );

   always_comb begin
      state_in     = state_ff;
      regs_in      = regs_ff;
      exec_go      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               exec_go      = 1'b1;
               state_in     = SEQ_IDLE;
               regs_in      = step_nxt;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, step_nxt.error, step_nxt.outcome, step_nxt.busy,
                               step_rsp.read_byte, step_rsp.tx_byte, step_rsp.action};
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         regs_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff      <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req_item;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_err_code_outcome : assert property (@(posedge clock) disable iff (reset)
      (regs_ff.error != 8'h00) |-> (regs_ff.outcome == OUT_ERR))
      else $error("error code kept without error outcome");

   a_busy_no_outcome : assert property (@(posedge clock) disable iff (reset)
      regs_ff.busy |-> (regs_ff.outcome == OUT_NONE))
      else $error("outcome reported while transfer still busy");

   a_size_bound : assert property (@(posedge clock) disable iff (reset)
      CMP_W'(regs_ff.size) <= CMP_W'(BUF_DEPTH))
      else $error("message size beyond buffer depth");

   a_send_keeps_busy : assert property (@(posedge clock) disable iff (reset)
      (exec_go && (step_rsp.action == ACT_SEND)) |=> (regs_ff.busy && rsp_tvalid))
      else $error("send action without busy transfer and response");

endmodule

// ===== hdl/i2cms_buf_mem.sv =====
// Message buffer: one write port, one registered read port.
module i2cms_buf_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/i2cms_step.sv =====
// Update logic: applies one host operation or bus event to the sequencer state.
module i2cms_step #(
   parameter int BUF_DEPTH = 16,
   parameter int AW        = 4
) (
   input  i2cms_pkg::req_item_type item,
   input  logic [7:0]              buf_data,
   input  i2cms_pkg::seq_regs_type cur,
   output i2cms_pkg::seq_regs_type nxt,
   output i2cms_pkg::step_rsp_type rsp,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [7:0]              wr_data
);
   import i2cms_pkg::*;

   localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(BUF_DEPTH);

   logic [7:0]       st_m;
   logic [PTR_W-1:0] ptr0;
   logic [PTR_W-1:0] ptr1;
   logic             idx_ok;
   logic             ptr_ok;
   logic             ptr0_ok;

   always_comb begin
      st_m    = item.status & STATUS_MASK;
      idx_ok  = CMP_W'(item.index) < DEPTH_W;
      ptr_ok  = CMP_W'(cur.ptr) < DEPTH_W;
      ptr0    = ((st_m == ST_START) || (st_m == ST_REP_START)) ? '0 : cur.ptr;
      ptr0_ok = CMP_W'(ptr0) < DEPTH_W;
      ptr1    = (cur.ptr == PTR_MAX) ? PTR_MAX : cur.ptr + 1'b1;

      nxt           = cur;
      rsp.action    = ACT_NONE;
      rsp.tx_byte   = '0;
      rsp.read_byte = '0;
      wr_en         = 1'b0;
      wr_addr       = AW'(CMP_W'(item.index));
      wr_data       = item.data_byte;

      case (item.op)
         OP_LOAD: begin
            wr_en = !cur.busy && idx_ok;
         end
         OP_START: begin
            if (!cur.busy) begin
               nxt.size    = (CMP_W'(item.count) > DEPTH_W) ? PTR_W'(BUF_DEPTH) : item.count;
               nxt.outcome = OUT_NONE;
               nxt.error   = '0;
               nxt.busy    = 1'b1;
            end
         end
         OP_READ: begin
            if (!cur.busy && idx_ok) begin
               rsp.read_byte = buf_data;
            end
         end
         OP_EVENT: begin
            if (cur.busy) begin
               // received bytes land at the current pointer
               wr_addr = AW'(CMP_W'(cur.ptr));
               wr_data = item.rx_byte;
               case (st_m)
                  ST_START, ST_REP_START, ST_MTX_ADR_ACK, ST_MTX_DATA_ACK: begin
                     nxt.ptr = ptr0;
                     if ((ptr0 < cur.size) && ptr0_ok) begin
                        rsp.tx_byte = buf_data;
                        rsp.action  = ACT_SEND;
                        nxt.ptr     = ptr0 + 1'b1;
                     end else begin
                        rsp.action  = ACT_STOP;
                        nxt.outcome = OUT_OK;
                        nxt.busy    = 1'b0;
                     end
                  end
                  ST_MRX_DATA_ACK: begin
                     wr_en      = ptr_ok;
                     nxt.ptr    = ptr1;
                     rsp.action = ((PTR_W+1)'(ptr1) + 1'b1 < (PTR_W+1)'(cur.size)) ?
                                  ACT_RX_ACK : ACT_RX_NACK;
                  end
                  ST_MRX_ADR_ACK: begin
                     rsp.action = ((PTR_W+1)'(cur.ptr) + 1'b1 < (PTR_W+1)'(cur.size)) ?
                                  ACT_RX_ACK : ACT_RX_NACK;
                  end
                  ST_MRX_DATA_NACK: begin
                     wr_en       = ptr_ok;
                     rsp.action  = ACT_STOP;
                     nxt.outcome = OUT_OK;
                     nxt.busy    = 1'b0;
                  end
                  ST_ARB_LOST: begin
                     rsp.action = ACT_RESTART;
                  end
                  default: begin
                     rsp.action  = ACT_ABORT;
                     nxt.outcome = OUT_ERR;
                     nxt.error   = st_m;
                     nxt.busy    = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            rsp.action = ACT_NONE;
         end
      endcase
   end

endmodule
